@@ src/bta_pkg.sv @@
// Package with the shared constants, types and helper functions of the id allocator.
package bta_pkg;

	localparam int NodeBits = 64;
	localparam int LeafCount = 64;
	localparam int NodeCount = LeafCount + 1;
	localparam int IdBits = 12;
	localparam int AddrBits = 7;
	localparam int BitIdxBits = 6;

	typedef logic [NodeBits-1:0] word_t;

	typedef enum logic [1:0] {
		REQ_ALLOC = 2'd0,
		REQ_FREE  = 2'd1,
		REQ_FIND  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NONE     = 2'd1,
		ST_BAD_RNG  = 2'd2,
		ST_BAD_FREE = 2'd3
	} status_t;

	// Mask of bits lo..hi inclusive.
	function automatic word_t range_mask(input logic [BitIdxBits-1:0] lo,
			input logic [BitIdxBits-1:0] hi);
		word_t m;
		m = '0;
		for (int i = 0; i < NodeBits; i++) begin
			m[i] = (BitIdxBits'(i) >= lo) && (BitIdxBits'(i) <= hi);
		end
		return m;
	endfunction

	// Index of the lowest set bit, and whether any bit is set.
	function automatic logic [BitIdxBits:0] lowest_set(input word_t w);
		logic [BitIdxBits:0] r;
		r = '0;
		for (int i = NodeBits - 1; i >= 0; i--) begin
			if (w[i]) begin
				r = {1'b1, BitIdxBits'(i)};
			end
		end
		return r;
	endfunction

endpackage

@@ src/bitmap_tree_id_allocator.sv @@
// Top level of the two-level bitmap tree id allocator.
//
// One request is taken per input transfer on req_valid/req_stall with the
// fields req_type, range_min, range_max and free_id. Each request yields
// exactly one result transfer on res_valid/res_stall carrying result_id and
// status. The block works on one request at a time: req_stall stays high
// from acceptance until the result has been taken by the receiver.
// The tree lives in a 65-word RAM (root at address 0, leaves at 1..64) with
// a single port; every step of the sequencer is one RAM read or write.
// Allocate: root read, one leaf read per candidate leaf (normally one, one
// more when the low edge leaf has nothing free in range), leaf write and,
// when the leaf became full, a root update that reads the root word and
// then writes it back edited. Free: leaf read, leaf write and, when the
// leaf was full, the root update; a double free ends after the leaf read.
// Find reads the leaf words in order from leaf 0 until one holds a used
// id. Min above max on an allocate and the unused request type go straight
// to the result. The next request is accepted at the earliest in the cycle
// after the result transfer.
// After reset the sequencer first sweeps all 65 words to all ones with
// req_stall held high; no transfer is taken during that pass.
// When the receiver stalls, the result is held in its output register and
// no new request is taken until it has been transferred.
module bitmap_tree_id_allocator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [1:0]  req_type,
	input  logic [11:0] range_min,
	input  logic [11:0] range_max,
	input  logic [11:0] free_id,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [11:0] result_id,
	output logic [1:0]  status
);
	typedef enum logic [10:0] {
		S_CLEAR  = 11'b00000000001,
		S_IDLE   = 11'b00000000010,
		S_RROOT  = 11'b00000000100,
		S_WROOT  = 11'b00000001000,
		S_PICK   = 11'b00000010000,
		S_RLEAF  = 11'b00000100000,
		S_WLEAF  = 11'b00001000000,
		S_LEAFCK = 11'b00010000000,
		S_RWAIT  = 11'b00100000000,
		S_FSCAN  = 11'b01000000000,
		S_DONE   = 11'b10000000000
	} state_t;

	state_t state_q;
	logic [bta_pkg::AddrBits-1:0] addr_q;
	logic [bta_pkg::AddrBits-1:0] ram_addr;
	logic ram_we;
	bta_pkg::word_t ram_wdata, ram_rdata;
	logic [1:0] kind_q;
	logic [11:0] lo_q, hi_q, fid_q;
	bta_pkg::word_t root_q, cand_q;
	logic [5:0] leaf_q;
	logic set_root_q;
	logic [11:0] rid_q;
	logic [1:0] st_q;
	logic rvalid_q;
	logic [bta_pkg::AddrBits-1:0] clr_q;

	bta_ram #(.Width(bta_pkg::NodeBits), .Depth(bta_pkg::NodeCount)) u_ram (
		.clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
	);

	// Leaf-level bit window of the current leaf within the range.
	logic [5:0] blo, bhi;
	always_comb begin
		blo = (lo_q[11:6] == leaf_q) ? lo_q[5:0] : 6'd0;
		bhi = (hi_q[11:6] == leaf_q) ? hi_q[5:0] : 6'd63;
	end

	logic [6:0] leaf_hit, cand_hit, used_hit;
	bta_pkg::word_t leaf_av;
	assign leaf_av = ram_rdata & bta_pkg::range_mask(blo, bhi);
	assign leaf_hit = bta_pkg::lowest_set(leaf_av);
	assign cand_hit = bta_pkg::lowest_set(cand_q);
	assign used_hit = bta_pkg::lowest_set(~ram_rdata);

	always_comb begin
		ram_we = 1'b0;
		ram_addr = addr_q;
		ram_wdata = ram_rdata;
		case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q;
				ram_wdata = '1;
			end
			S_WLEAF: begin
				ram_we = 1'b1;
				ram_addr = {1'b0, leaf_q} + 7'd1;
				ram_wdata = (kind_q == bta_pkg::REQ_FREE) ?
					(root_q | (64'd1 << fid_q[5:0])) : (root_q & ~(64'd1 << rid_q[5:0]));
			end
			S_WROOT: begin
				// The root is read first; then the edited word is written.
				ram_we = (clr_q == 7'd1);
				ram_addr = '0;
				ram_wdata = set_root_q ? (ram_rdata | (64'd1 << leaf_q)) :
					(ram_rdata & ~(64'd1 << leaf_q));
			end
			default: ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE) || rvalid_q;
	assign res_valid = rvalid_q;
	assign result_id = rid_q;
	assign status = st_q;

	// root_q also serves as a holding register for the leaf word being edited.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
			rvalid_q <= 1'b0;
			addr_q <= '0;
		end else begin
			if (rvalid_q && !res_stall) begin
				rvalid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 7'd1;
					if (clr_q == 7'(bta_pkg::NodeCount - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_valid && !req_stall) begin
						kind_q <= req_type;
						lo_q <= range_min;
						hi_q <= range_max;
						fid_q <= free_id;
						rid_q <= '0;
						st_q <= bta_pkg::ST_NONE;
						case (req_type)
							bta_pkg::REQ_ALLOC: begin
								if (range_min > range_max) begin
									st_q <= bta_pkg::ST_BAD_RNG;
									state_q <= S_DONE;
								end else begin
									addr_q <= '0;
									state_q <= S_RWAIT;
								end
							end
							bta_pkg::REQ_FREE: begin
								leaf_q <= free_id[11:6];
								addr_q <= {1'b0, free_id[11:6]} + 7'd1;
								state_q <= S_RLEAF;
							end
							bta_pkg::REQ_FIND: begin
								leaf_q <= '0;
								addr_q <= 7'd1;
								state_q <= S_RWAIT;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_RWAIT: begin
					// Read data for addr_q is valid next cycle.
					state_q <= (kind_q == bta_pkg::REQ_FIND) ? S_FSCAN : S_PICK;
					if (kind_q == bta_pkg::REQ_ALLOC) begin
						cand_q <= '0;
					end
				end
				S_PICK: begin
					// First visit: root word just read; mask to the range.
					cand_q <= ram_rdata & bta_pkg::range_mask(lo_q[11:6], hi_q[11:6]);
					state_q <= S_LEAFCK;
					leaf_q <= '0;
					addr_q <= '0;
				end
				S_LEAFCK: begin
					if (!cand_hit[6]) begin
						state_q <= S_DONE;
					end else begin
						leaf_q <= cand_hit[5:0];
						cand_q <= cand_q & ~(64'd1 << cand_hit[5:0]);
						addr_q <= {1'b0, cand_hit[5:0]} + 7'd1;
						state_q <= S_RLEAF;
					end
				end
				S_RLEAF: begin
					state_q <= S_RROOT;
				end
				S_RROOT: begin
					root_q <= ram_rdata;
					if (kind_q == bta_pkg::REQ_FREE) begin
						if (ram_rdata[fid_q[5:0]]) begin
							st_q <= bta_pkg::ST_BAD_FREE;
							state_q <= S_DONE;
						end else begin
							set_root_q <= (ram_rdata == '0);
							st_q <= bta_pkg::ST_OK;
							state_q <= S_WLEAF;
						end
					end else if (leaf_hit[6]) begin
						rid_q <= {leaf_q, leaf_hit[5:0]};
						st_q <= bta_pkg::ST_OK;
						set_root_q <= 1'b0;
						state_q <= S_WLEAF;
					end else begin
						state_q <= S_LEAFCK;
					end
				end
				S_WLEAF: begin
					// Root update needed if the leaf became full on an allocate or was full on a free.
					if ((kind_q == bta_pkg::REQ_FREE && set_root_q) ||
						(kind_q == bta_pkg::REQ_ALLOC &&
						(root_q & ~(64'd1 << rid_q[5:0])) == '0)) begin
						addr_q <= '0;
						state_q <= S_WROOT;
						clr_q <= 7'd0;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WROOT: begin
					// The root read is issued first; then the edited root is written.
					if (clr_q == 7'd0) begin
						clr_q <= 7'd1;
						state_q <= S_WROOT;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FSCAN: begin
					if (~ram_rdata != '0) begin
						rid_q <= {leaf_q, used_hit[5:0]};
						st_q <= bta_pkg::ST_OK;
						state_q <= S_DONE;
					end else if (leaf_q == 6'd63) begin
						state_q <= S_DONE;
					end else begin
						leaf_q <= leaf_q + 6'd1;
						addr_q <= addr_q + 7'd1;
						state_q <= S_RWAIT;
					end
				end
				S_DONE: begin
					if (!rvalid_q) begin
						rvalid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	ap_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> req_stall) else $error("request taken while busy");
	ap_ok_only_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(state_q == S_DONE)) else $error("stray result");
	ap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(result_id)))
		else $error("result dropped");
	ap_nonok_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && status != bta_pkg::ST_OK) |-> (result_id == '0))
		else $error("nonzero id with error status");
endmodule

@@ src/bta_ram.sv @@
// Generic single-port RAM with registered read data.
module bta_ram #(
	parameter int Width = 64,
	parameter int Depth = 65
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

@@ dv/bitmap_tree_id_allocator_test.sv @@
// Self-checking testbench of the bitmap tree id allocator.
module bitmap_tree_id_allocator_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int Capacity = bta_pkg::NodeBits * bta_pkg::LeafCount;
	localparam int CycleLimit = 2000000;

	typedef struct packed {
		logic [11:0]       id;
		bta_pkg::status_t  st;
	} answer_t;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_stall;
	logic [1:0]  req_type;
	logic [11:0] range_min;
	logic [11:0] range_max;
	logic [11:0] free_id;
	logic        res_valid;
	logic        res_stall;
	logic [11:0] result_id;
	logic [1:0]  status;

	bitmap_tree_id_allocator u_dut (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.req_type(req_type), .range_min(range_min),
		.range_max(range_max), .free_id(free_id),
		.res_valid(res_valid), .res_stall(res_stall),
		.result_id(result_id), .status(status)
	);

	// The predictor only needs the leaf bits: the root word is a summary of
	// them, so the lowest free id in a range is found directly on the leaves.
	logic    id_free [Capacity];
	answer_t pending_answers[$];
	int      errors;
	int      results_seen;
	int      items_sent;
	int      cycles;
	int      send_idle_pct;
	int      stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog over the whole run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("%0t timeout after %0d cycles", $time, cycles);
			$display("[bitmap_tree_id_allocator] ERROR");
			$finish;
		end
	end

	// The receiver stalls at random with the percentage of the current phase.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
		end else begin
			res_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Every result transfer is compared with the oldest expectation.
	always @(posedge clk) begin
		answer_t want;
		if (arst_n && res_valid && !res_stall) begin
			results_seen <= results_seen + 1;
			if (pending_answers.size() == 0) begin
				$display("%0t unexpected result id=%0d status=%0d", $time, result_id, status);
				errors = errors + 1;
			end else begin
				want = pending_answers.pop_front();
				if (result_id !== want.id) begin
					$display("%0t result_id expected %0d actual %0d", $time, want.id,
						result_id);
					errors = errors + 1;
				end
				if (status !== want.st) begin
					$display("%0t status expected %0d actual %0d", $time, want.st, status);
					errors = errors + 1;
				end
			end
		end
	end

	// Computes the answer of one request and updates the free map.
	function automatic answer_t predict_request(logic [1:0] kind, logic [11:0] lo,
			logic [11:0] hi, logic [11:0] fid);
		answer_t a;
		a.id = '0;
		a.st = bta_pkg::ST_NONE;
		case (kind)
			bta_pkg::REQ_ALLOC: begin
				if (lo > hi) begin
					a.st = bta_pkg::ST_BAD_RNG;
				end else begin
					for (int i = lo; i <= hi; i++) begin
						if (id_free[i]) begin
							id_free[i] = 1'b0;
							a.id = 12'(i);
							a.st = bta_pkg::ST_OK;
							break;
						end
					end
				end
			end
			bta_pkg::REQ_FREE: begin
				if (id_free[fid]) begin
					a.st = bta_pkg::ST_BAD_FREE;
				end else begin
					id_free[fid] = 1'b1;
					a.st = bta_pkg::ST_OK;
				end
			end
			bta_pkg::REQ_FIND: begin
				for (int i = 0; i < Capacity; i++) begin
					if (!id_free[i]) begin
						a.id = 12'(i);
						a.st = bta_pkg::ST_OK;
						break;
					end
				end
			end
			default: ;
		endcase
		return a;
	endfunction

	// Sends one request; the expectation is recorded at the accepting edge.
	// The valid stays high after the transfer until the next idle cycle or
	// request replaces it, so each edge sees at most one assignment.
	task automatic send_request(logic [1:0] kind, logic [11:0] lo, logic [11:0] hi,
			logic [11:0] fid);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type  <= kind;
		range_min <= lo;
		range_max <= hi;
		free_id   <= fid;
		@(posedge clk);
		while (req_stall) begin
			@(posedge clk);
		end
		pending_answers.push_back(predict_request(kind, lo, hi, fid));
		items_sent++;
	endtask

	// Extremes of every field, every request type and every named special case.
	task automatic test_directed();
		send_request(bta_pkg::REQ_FIND, 12'd0, 12'd0, 12'd0);
		send_request(bta_pkg::REQ_FREE, 12'd0, 12'd0, 12'd5);
		send_request(bta_pkg::REQ_ALLOC, 12'd10, 12'd9, 12'd0);
		send_request(bta_pkg::REQ_ALLOC, 12'd0, 12'd0, 12'd0);
		send_request(bta_pkg::REQ_ALLOC, 12'd0, 12'd0, 12'd0);
		send_request(bta_pkg::REQ_ALLOC, 12'd4095, 12'd4095, 12'd4095);
		send_request(bta_pkg::REQ_ALLOC, 12'd63, 12'd64, 12'd0);
		send_request(bta_pkg::REQ_ALLOC, 12'd63, 12'd64, 12'd0);
		send_request(bta_pkg::REQ_ALLOC, 12'd0, 12'd4095, 12'd0);
		send_request(bta_pkg::REQ_FIND, 12'd4095, 12'd4095, 12'd4095);
		send_request(bta_pkg::REQ_FREE, 12'd0, 12'd0, 12'd0);
		send_request(bta_pkg::REQ_FREE, 12'd0, 12'd0, 12'd0);
		send_request(bta_pkg::REQ_FREE, 12'd0, 12'd0, 12'd4095);
		send_request(bta_pkg::REQ_NONE, 12'd4095, 12'd4095, 12'd4095);
		send_request(bta_pkg::REQ_FREE, 12'hAAA, 12'h555, 12'd63);
		send_request(bta_pkg::REQ_FIND, 12'd0, 12'd0, 12'd0);
		// Fill one whole leaf so its root bit clears, then reopen it.
		for (int i = 0; i < 65; i++) begin
			send_request(bta_pkg::REQ_ALLOC, 12'd128, 12'd191, 12'd0);
		end
		send_request(bta_pkg::REQ_FREE, 12'd0, 12'd0, 12'd150);
		send_request(bta_pkg::REQ_ALLOC, 12'd100, 12'd300, 12'd0);
	endtask

	// Random mix of requests in one idling phase; ranges are mostly narrow so
	// that leaves fill up, and frees mostly aim at the low end of the range.
	task automatic test_random_phase(int count, int idle, int stall);
		logic [11:0] lo;
		logic [11:0] hi;
		int pick;
		send_idle_pct = idle;
		stall_pct = stall;
		for (int n = 0; n < count; n++) begin
			lo = 12'($urandom);
			hi = lo + 12'($urandom_range(130));
			if ($urandom_range(9) == 0) hi = 12'($urandom);
			pick = $urandom_range(99);
			if (pick < 50) begin
				send_request(bta_pkg::REQ_ALLOC, lo, hi, 12'($urandom));
			end else if (pick < 85) begin
				send_request(bta_pkg::REQ_FREE, lo, hi, ($urandom_range(3) == 0) ?
					12'($urandom) : lo);
			end else if (pick < 95) begin
				send_request(bta_pkg::REQ_FIND, lo, hi, 12'($urandom));
			end else begin
				send_request(2'($urandom), 12'($urandom), 12'($urandom), 12'($urandom));
			end
		end
	endtask

	initial begin
		int drain;
		errors = 0;
		results_seen = 0;
		items_sent = 0;
		cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		req_valid = 1'b0;
		req_type = bta_pkg::REQ_ALLOC;
		range_min = '0;
		range_max = '0;
		free_id = '0;
		for (int i = 0; i < Capacity; i++) id_free[i] = 1'b1;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random_phase(190, 0, 0);
		test_random_phase(190, 59, 0);
		test_random_phase(190, 0, 59);
		test_random_phase(190, 16, 16);
		req_valid <= 1'b0;
		stall_pct = 0;
		drain = 0;
		while (pending_answers.size() != 0 && drain < 20000) begin
			@(posedge clk);
			drain++;
		end
		repeat (100) @(posedge clk);
		if (pending_answers.size() != 0) begin
			$display("%0t %0d results never arrived", $time, pending_answers.size());
			errors++;
		end
		$display("Sent %0d allocate, free, find and unused requests over four idling phases,",
			items_sent);
		$display("checked %0d results with %0d mismatches.", results_seen, errors);
		if (errors == 0) begin
			$display("[bitmap_tree_id_allocator] OK");
		end else begin
			$display("[bitmap_tree_id_allocator] ERROR");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/bta_pkg.sv
src/bta_ram.sv
src/bitmap_tree_id_allocator.sv
dv/bitmap_tree_id_allocator_test.sv
